// ===== sv/dtq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the delta timer queue
// Capacity, operation and status codes, entry and walk-token types.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [15:0] d;
    logic [7:0]  h;
    logic [15:0] a;
  } entry_t;

  typedef struct packed {
    logic             vld;
    logic             op;
    logic [15:0]      rank;
    logic [7:0]       hid;
    logic [15:0]      arg;
    logic [CNT_W-1:0] cnt;
    logic             placed;
    logic             found;
    logic [15:0]      acc;
    logic [15:0]      sum;
    entry_t           carry;
    entry_t           head;
    entry_t           last;
  } wave_t;

  typedef struct packed {
    logic [1:0]       status;
    entry_t           head;
    entry_t           last;
    logic [15:0]      sum;
    logic [CNT_W-1:0] cnt;
  } result_t;

endpackage

// ===== sv/dtq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_cell: one slot of the delta queue
// Holds one entry and updates it as the walk token passes, then hands the
// token on to the next slot through a register.
// ----------------------------------------------------------------------------
module dtq_cell import dtq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] cell_idx,
  input  wave_t            wave_in,
  input  entry_t           next_ent,
  output entry_t           ent,
  output wave_t            wave_out
);

  entry_t           ent_r;
  entry_t           ent_nxt;
  wave_t            wave_r;
  wave_t            wave_nxt;
  logic             occ;
  logic             full;
  logic             has_next;
  logic             hit;
  logic             take;
  logic             in_new;
  logic [16:0]      acc_sum;
  logic [15:0]      nd;
  logic [CNT_W-1:0] idx_p1;

  always_comb begin
    wave_nxt = wave_in;
    ent_nxt  = ent_r;
    occ      = cell_idx < wave_in.cnt;
    full     = wave_in.cnt == CNT_W'(CAPACITY);
    idx_p1   = cell_idx + CNT_W'(1);
    has_next = idx_p1 < wave_in.cnt;
    acc_sum  = {1'b0, wave_in.acc} + {1'b0, ent_r.d};
    nd       = wave_in.rank - wave_in.acc;
    hit      = 1'b0;
    take     = 1'b0;
    in_new   = 1'b0;
    if (wave_in.op == OP_INSERT) begin
      if (!full) begin
        if (occ) begin
          if (!wave_in.placed) begin
            if (acc_sum > {1'b0, wave_in.rank}) begin
              ent_nxt          = '{d: nd, h: wave_in.hid, a: wave_in.arg};
              wave_nxt.carry   = '{d: ent_r.d - nd, h: ent_r.h, a: ent_r.a};
              wave_nxt.placed  = 1'b1;
            end else begin
              wave_nxt.acc = acc_sum[15:0];
            end
          end else begin
            ent_nxt        = wave_in.carry;
            wave_nxt.carry = ent_r;
          end
        end else if (cell_idx == wave_in.cnt) begin
          ent_nxt = wave_in.placed ? wave_in.carry
                                   : entry_t'{d: nd, h: wave_in.hid, a: wave_in.arg};
          wave_nxt.placed = 1'b1;
        end
      end
      in_new = full ? occ : (cell_idx <= wave_in.cnt);
    end else begin
      if (occ) begin
        hit  = !wave_in.found && (ent_r.h == wave_in.hid);
        take = wave_in.found || hit;
        if (take) begin
          wave_nxt.found = 1'b1;
          if (has_next) begin
            ent_nxt = '{d: next_ent.d + (hit ? ent_r.d : 16'd0),
                        h: next_ent.h, a: next_ent.a};
          end
        end
      end
      in_new = occ && (has_next || !take);
    end
    if (in_new) begin
      wave_nxt.sum  = wave_in.sum + ent_nxt.d;
      wave_nxt.last = ent_nxt;
      if (cell_idx == '0) begin
        wave_nxt.head = ent_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wave_in.vld) begin
      ent_r <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign ent      = ent_r;
  assign wave_out = wave_r;

endmodule

// ===== sv/delta_timer_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_timer_queue_top: bounded delta event queue
// Insert places an event by absolute rank (ties after existing entries),
// remove deletes the first entry with a matching handler id. Each command
// returns one word with status, head, last entry, rank sum and count.
//
// Input channel in_*: one command word per handshake (op, rank, handler id,
// argument tag). Result channel out_*: one word per command, in order.
// A command walks a chain of CAPACITY slots, one slot per cycle; its
// result word is registered as it leaves the last slot. The next command
// waits for that walk to end, so one command is in the chain at a time.
// Results go through a two-word output buffer: a command is accepted while
// one result waits, and input stalls only when a second result is held.
// Synchronous reset empties the queue and drops pending words; slot
// contents are not cleared and never read before being written.
// ----------------------------------------------------------------------------
module delta_timer_queue_top import dtq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [15:0]      in_new_rank,
  input  logic [7:0]       in_handler_id,
  input  logic [15:0]      in_arg_tag,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_head_rank,
  output logic [7:0]       out_head_handler,
  output logic [15:0]      out_head_arg,
  output logic [15:0]      out_last_delta,
  output logic [7:0]       out_last_handler,
  output logic [15:0]      out_rank_sum,
  output logic [CNT_W-1:0] out_entry_count
);

  wave_t            waves [CAPACITY+1];
  entry_t           ents  [CAPACITY];
  logic [CAPACITY-1:0] wave_vlds;

  logic             busy_r;
  logic [CNT_W-1:0] count_r;
  logic             out_vld_r;
  result_t          out_r;
  logic             spare_vld_r;
  result_t          spare_r;

  logic             in_fire;
  logic             out_fire;
  wave_t            fin;
  result_t          res;

  assign in_ready = !busy_r && !spare_vld_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_vld_r && out_ready;

  always_comb begin
    waves[0]        = '0;
    waves[0].vld    = in_fire;
    waves[0].op     = in_op;
    waves[0].rank   = in_new_rank;
    waves[0].hid    = in_handler_id;
    waves[0].arg    = in_arg_tag;
    waves[0].cnt    = count_r;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t nxt;
    if (i == CAPACITY - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ents[i+1];
    end
    dtq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CNT_W'(i)),
      .wave_in  (waves[i]),
      .next_ent (nxt),
      .ent      (ents[i]),
      .wave_out (waves[i+1])
    );
    assign wave_vlds[i] = waves[i+1].vld;
  end

  assign fin = waves[CAPACITY];

  always_comb begin
    res.head   = fin.head;
    res.last   = fin.last;
    res.sum    = fin.sum;
    res.status = ST_OK;
    res.cnt    = fin.cnt;
    if (fin.op == OP_INSERT) begin
      if (fin.cnt == CNT_W'(CAPACITY)) begin
        res.status = ST_FULL;
      end else begin
        res.cnt = fin.cnt + CNT_W'(1);
      end
    end else begin
      if (!fin.found) begin
        res.status = ST_NOT_FOUND;
      end else begin
        res.cnt = fin.cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_vld_r   <= 1'b0;
      spare_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end
      if (fin.vld) begin
        busy_r  <= 1'b0;
        count_r <= res.cnt;
        if (!out_vld_r || out_fire) begin
          out_r     <= res;
          out_vld_r <= 1'b1;
        end else begin
          spare_r     <= res;
          spare_vld_r <= 1'b1;
        end
      end else if (out_fire) begin
        if (spare_vld_r) begin
          out_r       <= spare_r;
          spare_vld_r <= 1'b0;
        end else begin
          out_vld_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_r.status;
  assign out_head_rank    = out_r.head.d;
  assign out_head_handler = out_r.head.h;
  assign out_head_arg     = out_r.head.a;
  assign out_last_delta   = out_r.last.d;
  assign out_last_handler = out_r.last.h;
  assign out_rank_sum     = out_r.sum;
  assign out_entry_count  = out_r.cnt;

  // at most one command walks the chain
  a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wave_vlds))
    else $error("more than one command in the slot chain");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin.vld |-> busy_r && !spare_vld_r)
    else $error("walk finished with no command pending or no buffer room");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.status == ST_FULL) |-> out_r.cnt == CNT_W'(CAPACITY))
    else $error("full status with queue not full");

endmodule
